// ===== hdl/spi_master_bitbang_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// SPI bit-bang engine assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_BITBANG_ENGINE_UNIT_ASSERT_SVH
`define SPI_MASTER_BITBANG_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define SMBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/spi_mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI bit-bang engine package
// Word size, derived widths and operation / device codes.
// ----------------------------------------------------------------------------
package spi_mbe_pkg;

	localparam int BITS_PER_WORD = 8;
	localparam int CNT_W         = $clog2(2 * BITS_PER_WORD);
	localparam int WIDE_W        = (BITS_PER_WORD > 8) ? BITS_PER_WORD : 8;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * BITS_PER_WORD - 1);

	typedef logic [BITS_PER_WORD-1:0] word_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [1:0]               code_t;

	localparam code_t MODE_WRITE  = 2'd0;
	localparam code_t MODE_READ   = 2'd1;
	localparam code_t MODE_SELECT = 2'd2;

	localparam code_t DEV_FLASH  = 2'd0;
	localparam code_t DEV_RADIO1 = 2'd1;
	localparam code_t DEV_RADIO2 = 2'd2;
	localparam code_t DEV_FPGA   = 2'd3;

endpackage

// ===== hdl/spi_master_bitbang_engine_unit.sv =====
// ----------------------------------------------------------------------------
// SPI bit-bang engine
// Mode 3, MSB-first SPI master advanced by one pin tick per input beat.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// in      | in_valid / in_ready  | start_req mode device tx_byte keep_selected din
// out     | out_valid / out_ready| sck dout sck_flash dout_flash sel_*_n rx_byte
//         |                      | rx_valid busy_res
//
// One beat in, one beat out. A beat passes through the input register and
// then leaves through the result register; one beat per cycle is sustained
// while out is ready. The tick logic runs when the input register hands off
// to the result register, so a stall on out holds the serial state. An
// operation spans one start beat plus 2*BITS_PER_WORD shift beats. Reset
// clears control and pin state at once.
`include "spi_master_bitbang_engine_unit_assert.svh"

module spi_master_bitbang_engine_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     start_req,
	input  spi_mbe_pkg::code_t       mode,
	input  spi_mbe_pkg::code_t       device,
	input  logic [7:0]               tx_byte,
	input  logic                     keep_selected,
	input  logic                     din,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     sck,
	output logic                     dout,
	output logic                     sck_flash,
	output logic                     dout_flash,
	output logic                     sel_flash_n,
	output logic                     sel_radio1_n,
	output logic                     sel_radio2_n,
	output logic [7:0]               rx_byte,
	output logic                     rx_valid,
	output logic                     busy_res
);
	import spi_mbe_pkg::*;

	// input register
	logic       valid_s1;
	logic       start_s1;
	code_t      mode_s1;
	code_t      dev_s1;
	logic [7:0] tx_s1;
	logic       keep_s1;
	logic       din_s1;

	// engine state
	logic       active_q, is_read_q, flash_q, release_q;
	cnt_t       cnt_q;
	word_t      shifter_q;
	logic [2:0] sel_n_q;
	logic       sck_q, dout_q, sck_fl_q, dout_fl_q;

	logic       active_d, is_read_d, flash_d, release_d;
	cnt_t       cnt_d;
	word_t      shifter_d;
	logic [2:0] sel_n_d;
	logic       sck_d, dout_d, sck_fl_d, dout_fl_d;
	logic       rx_valid_d;
	logic [7:0] rx_byte_d;

	// result register
	logic       out_valid_s2;
	logic       rx_valid_s2;
	logic [7:0] rx_byte_s2;
	logic       busy_s2;

	logic       adv;
	logic       op_start;
	logic [WIDE_W-1:0] tx_wide;
	logic [WIDE_W-1:0] sh_wide;

	assign adv      = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign op_start = (mode_s1 == MODE_WRITE) || (mode_s1 == MODE_READ);
	assign tx_wide  = WIDE_W'(tx_s1);
	assign sh_wide  = WIDE_W'(shifter_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			start_s1 <= start_req;
			mode_s1  <= mode;
			dev_s1   <= device;
			tx_s1    <= tx_byte;
			keep_s1  <= keep_selected;
			din_s1   <= din;
		end
	end

	always_comb begin
		active_d   = active_q;
		is_read_d  = is_read_q;
		flash_d    = flash_q;
		release_d  = release_q;
		cnt_d      = cnt_q;
		shifter_d  = shifter_q;
		sel_n_d    = sel_n_q;
		sck_d      = sck_q;
		dout_d     = dout_q;
		sck_fl_d   = sck_fl_q;
		dout_fl_d  = dout_fl_q;
		rx_valid_d = 1'b0;
		rx_byte_d  = 8'd0;
		if (!active_q) begin
			if (start_s1) begin
				unique case (dev_s1)
					DEV_FLASH:  sel_n_d[0] = 1'b0;
					DEV_RADIO1: sel_n_d[1] = 1'b0;
					DEV_RADIO2: sel_n_d[2] = 1'b0;
					default:    ;
				endcase
				if (op_start) begin
					active_d  = 1'b1;
					cnt_d     = '0;
					is_read_d = (mode_s1 == MODE_READ);
					flash_d   = (dev_s1 == DEV_FLASH);
					release_d = !keep_s1;
					shifter_d = (mode_s1 == MODE_READ) ? '0 : tx_wide[BITS_PER_WORD-1:0];
					if (dev_s1 == DEV_FLASH) begin
						sck_fl_d = 1'b1;
					end else begin
						sck_d = 1'b1;
					end
				end else if (!keep_s1) begin
					sel_n_d = '1;
				end
			end
		end else begin
			if (!cnt_q[0]) begin
				// low phase: shift, drive or sample
				if (is_read_q) begin
					shifter_d = BITS_PER_WORD'({shifter_q, din_s1});
				end else begin
					shifter_d = BITS_PER_WORD'({shifter_q, 1'b0});
					if (flash_q) begin
						dout_fl_d = shifter_q[BITS_PER_WORD-1];
					end else begin
						dout_d = shifter_q[BITS_PER_WORD-1];
					end
				end
				if (flash_q) begin
					sck_fl_d = 1'b0;
				end else begin
					sck_d = 1'b0;
				end
			end else begin
				if (flash_q) begin
					sck_fl_d = 1'b1;
				end else begin
					sck_d = 1'b1;
				end
			end
			cnt_d = cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				// last high phase leaves shifter untouched
				active_d   = 1'b0;
				cnt_d      = '0;
				rx_valid_d = is_read_q;
				rx_byte_d  = is_read_q ? sh_wide[7:0] : 8'd0;
				if (release_q) begin
					sel_n_d = '1;
				end
				release_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			is_read_q <= 1'b0;
			flash_q   <= 1'b0;
			release_q <= 1'b0;
			cnt_q     <= '0;
			shifter_q <= '0;
			sel_n_q   <= '1;
			sck_q     <= 1'b1;
			dout_q    <= 1'b0;
			sck_fl_q  <= 1'b1;
			dout_fl_q <= 1'b0;
		end else if (adv) begin
			active_q  <= active_d;
			is_read_q <= is_read_d;
			flash_q   <= flash_d;
			release_q <= release_d;
			cnt_q     <= cnt_d;
			shifter_q <= shifter_d;
			sel_n_q   <= sel_n_d;
			sck_q     <= sck_d;
			dout_q    <= dout_d;
			sck_fl_q  <= sck_fl_d;
			dout_fl_q <= dout_fl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_valid_s2 <= rx_valid_d;
			rx_byte_s2  <= rx_byte_d;
			busy_s2     <= active_d;
		end
	end

	// pin levels live in the engine state and are only updated with a beat
	assign out_valid    = out_valid_s2;
	assign sck          = sck_q;
	assign dout         = dout_q;
	assign sck_flash    = sck_fl_q;
	assign dout_flash   = dout_fl_q;
	assign sel_flash_n  = sel_n_q[0];
	assign sel_radio1_n = sel_n_q[1];
	assign sel_radio2_n = sel_n_q[2];
	assign rx_byte      = rx_byte_s2;
	assign rx_valid     = rx_valid_s2;
	assign busy_res     = busy_s2;

	`SMBE_ASSERT_NOW(a_rx_not_busy, out_valid_s2 && rx_valid_s2, !busy_s2,
		"rx_valid raised while still busy")
	`SMBE_ASSERT_NOW(a_rx_zero, out_valid_s2 && !rx_valid_s2, rx_byte_s2 == 8'd0,
		"rx_byte nonzero without rx_valid")
	`SMBE_ASSERT_NOW(a_idle_cnt, !active_q, cnt_q == '0,
		"tick count not cleared while idle")
	`SMBE_ASSERT_NEXT(a_word_end, adv && active_q && (cnt_q == CNT_LAST), !active_q,
		"operation did not end after last tick")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI bit-bang engine testbench
// Drives a table of directed operations, then random operations with noisy
// ticks, through the beat handshake with random idle bursts on both sides.
// A tick-level model predicts every result beat but those of typed rows.
// ----------------------------------------------------------------------------
module tb_top;
	import spi_mbe_pkg::*;

	localparam code_t MODE_SELECT_ALT = 2'd3;
	localparam int    ITEMS_TOTAL     = 600;
	localparam int    QUIET_TAIL      = 120;

	typedef struct packed {
		logic       start;
		code_t      mode;
		code_t      device;
		logic [7:0] tx;
		logic       keep;
		logic       din;
	} beat_t;

	typedef struct packed {
		logic       sck;
		logic       dout;
		logic       sck_fl;
		logic       dout_fl;
		logic       sel_fl_n;
		logic       sel_r1_n;
		logic       sel_r2_n;
		logic [7:0] rx;
		logic       rx_ok;
		logic       busy;
	} pins_t;

	typedef struct packed {
		beat_t lead;
		word_t din_word;
		logic  typed;
		pins_t want;
	} op_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       start_req;
	code_t      mode;
	code_t      device;
	logic [7:0] tx_byte;
	logic       keep_selected;
	logic       din;
	logic       out_valid;
	logic       out_ready;
	logic       sck;
	logic       dout;
	logic       sck_flash;
	logic       dout_flash;
	logic       sel_flash_n;
	logic       sel_radio1_n;
	logic       sel_radio2_n;
	logic [7:0] rx_byte;
	logic       rx_valid;
	logic       busy_res;

	// bus model state, as after reset
	logic       bus_active = 1'b0;
	int         half_cnt   = 0;
	word_t      shreg      = '0;
	logic       rd_op      = 1'b0;
	logic       on_flash   = 1'b0;
	logic       drop_sel   = 1'b0;
	logic [2:0] sel_n      = 3'b111;
	logic       lv_sck     = 1'b1;
	logic       lv_dout    = 1'b0;
	logic       lv_sck_fl  = 1'b1;
	logic       lv_dout_fl = 1'b0;

	pins_t      pending_pins[$];
	pins_t      want_pins;
	op_row_t    dir_ops[$];
	int         mismatches = 0;
	int         items_sent = 0;
	int         out_beats  = 0;
	int         stall_left = 0;
	logic       quiet      = 1'b0;

	spi_master_bitbang_engine_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_req    (start_req),
		.mode         (mode),
		.device       (device),
		.tx_byte      (tx_byte),
		.keep_selected(keep_selected),
		.din          (din),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sck          (sck),
		.dout         (dout),
		.sck_flash    (sck_flash),
		.dout_flash   (dout_flash),
		.sel_flash_n  (sel_flash_n),
		.sel_radio1_n (sel_radio1_n),
		.sel_radio2_n (sel_radio2_n),
		.rx_byte      (rx_byte),
		.rx_valid     (rx_valid),
		.busy_res     (busy_res)
	);

	always #5 clk = ~clk;

	initial begin
		#(4_000_000);
		$display("tb_top failed");
		$finish;
	end

	// Advance the bus model by one tick and return the pin levels after it.
	function automatic pins_t next_pins(beat_t b);
		pins_t p;
		logic  lvl;
		p = '0;
		if (!bus_active) begin
			if (b.start) begin
				if (b.device != DEV_FPGA)
					sel_n[b.device] = 1'b0;
				if (b.mode == MODE_WRITE || b.mode == MODE_READ) begin
					bus_active = 1'b1;
					half_cnt   = 0;
					rd_op      = (b.mode == MODE_READ);
					on_flash   = (b.device == DEV_FLASH);
					drop_sel   = !b.keep;
					shreg      = rd_op ? word_t'(0) : word_t'(b.tx);
					if (on_flash)
						lv_sck_fl = 1'b1;
					else
						lv_sck = 1'b1;
				end else if (!b.keep) begin
					sel_n = 3'b111;
				end
			end
		end else begin
			// low phase drives or samples, high phase only raises the clock
			lvl = half_cnt[0];
			if (!half_cnt[0]) begin
				if (rd_op) begin
					shreg = (shreg << 1) | word_t'(b.din);
				end else begin
					if (on_flash)
						lv_dout_fl = shreg[BITS_PER_WORD-1];
					else
						lv_dout = shreg[BITS_PER_WORD-1];
					shreg = shreg << 1;
				end
			end
			if (on_flash)
				lv_sck_fl = lvl;
			else
				lv_sck = lvl;
			half_cnt++;
			if (half_cnt >= 2 * BITS_PER_WORD) begin
				bus_active = 1'b0;
				half_cnt   = 0;
				if (rd_op) begin
					p.rx_ok = 1'b1;
					p.rx    = 8'(shreg);
				end
				if (drop_sel)
					sel_n = 3'b111;
				drop_sel = 1'b0;
			end
		end
		p.sck      = lv_sck;
		p.dout     = lv_dout;
		p.sck_fl   = lv_sck_fl;
		p.dout_fl  = lv_dout_fl;
		p.sel_fl_n = sel_n[0];
		p.sel_r1_n = sel_n[1];
		p.sel_r2_n = sel_n[2];
		p.busy     = bus_active;
		return p;
	endfunction

	function automatic op_row_t mk_row(logic st, code_t m, code_t d, logic [7:0] tx,
			logic kp, word_t dw, logic typed, logic [2:0] want_sel_n);
		op_row_t r;
		r                = '0;
		r.lead.start     = st;
		r.lead.mode      = m;
		r.lead.device    = d;
		r.lead.tx        = tx;
		r.lead.keep      = kp;
		r.din_word       = dw;
		r.typed          = typed;
		r.want.sck       = 1'b1;
		r.want.sck_fl    = 1'b1;
		r.want.sel_fl_n  = want_sel_n[0];
		r.want.sel_r1_n  = want_sel_n[1];
		r.want.sel_r2_n  = want_sel_n[2];
		return r;
	endfunction

	function automatic beat_t rand_beat();
		beat_t b;
		b.start  = 1'($urandom_range(0, 1));
		b.mode   = code_t'($urandom_range(0, 3));
		b.device = code_t'($urandom_range(0, 3));
		b.tx     = 8'($urandom);
		b.keep   = 1'($urandom_range(0, 1));
		b.din    = 1'($urandom_range(0, 1));
		return b;
	endfunction

	task automatic report(string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report($sformatf("beat %0d: %s is %0h, expected %0h", out_beats, name, got, want));
	endtask

	task automatic send_beat(beat_t b, logic typed, pins_t want);
		pins_t p;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		start_req     <= b.start;
		mode          <= b.mode;
		device        <= b.device;
		tx_byte       <= b.tx;
		keep_selected <= b.keep;
		din           <= b.din;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = next_pins(b);
		pending_pins.push_back(typed ? want : p);
		items_sent++;
	endtask

	// Issue one request, then tick it through to the end of its word.
	task automatic run_op(beat_t b, word_t dw, logic typed, pins_t want);
		beat_t t;
		int    k;
		send_beat(b, typed, want);
		for (k = 0; k < 2 * BITS_PER_WORD && bus_active; k++) begin
			t     = rand_beat();
			t.din = k[0] ? t.din : dw[BITS_PER_WORD - 1 - k / 2];
			send_beat(t, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pins.size() == 0) begin
				report($sformatf("beat %0d: result with nothing expected", out_beats));
			end else begin
				want_pins = pending_pins.pop_front();
				check_field("sck", int'(sck), int'(want_pins.sck));
				check_field("dout", int'(dout), int'(want_pins.dout));
				check_field("sck_flash", int'(sck_flash), int'(want_pins.sck_fl));
				check_field("dout_flash", int'(dout_flash), int'(want_pins.dout_fl));
				check_field("sel_flash_n", int'(sel_flash_n), int'(want_pins.sel_fl_n));
				check_field("sel_radio1_n", int'(sel_radio1_n), int'(want_pins.sel_r1_n));
				check_field("sel_radio2_n", int'(sel_radio2_n), int'(want_pins.sel_r2_n));
				check_field("rx_byte", int'(rx_byte), int'(want_pins.rx));
				check_field("rx_valid", int'(rx_valid), int'(want_pins.rx_ok));
				check_field("busy_res", int'(busy_res), int'(want_pins.busy));
			end
			out_beats++;
		end
	end

	initial begin
		beat_t b;
		int    i;
		int    pick;
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		start_req     = 1'b0;
		mode          = MODE_WRITE;
		device        = DEV_FLASH;
		tx_byte       = 8'h00;
		keep_selected = 1'b0;
		din           = 1'b0;
		out_ready     = 1'b0;

		// idle and select-only rows come first, while the pins still sit at reset
		dir_ops.push_back(mk_row(1'b0, MODE_WRITE, DEV_FLASH, 8'h00, 1'b0, '0, 1'b1, 3'b111));
		dir_ops.push_back(mk_row(1'b1, MODE_SELECT, DEV_FLASH, 8'h00, 1'b0, '0, 1'b1, 3'b111));
		dir_ops.push_back(mk_row(1'b1, MODE_SELECT, DEV_RADIO1, 8'h00, 1'b1, '0, 1'b1, 3'b101));
		dir_ops.push_back(mk_row(1'b1, MODE_SELECT_ALT, DEV_RADIO2, 8'hFF, 1'b1, '0, 1'b1,
			3'b001));
		dir_ops.push_back(mk_row(1'b1, MODE_SELECT, DEV_FPGA, 8'h00, 1'b0, '0, 1'b1, 3'b111));
		dir_ops.push_back(mk_row(1'b0, MODE_READ, DEV_RADIO1, 8'hFF, 1'b1, '0, 1'b1, 3'b111));
		dir_ops.push_back(mk_row(1'b1, MODE_WRITE, DEV_FLASH, 8'hFF, 1'b0, '0, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_WRITE, DEV_FLASH, 8'h00, 1'b1, '1, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_READ, DEV_FLASH, 8'h00, 1'b1, 8'hA5, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_WRITE, DEV_RADIO1, 8'h80, 1'b1, '0, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_WRITE, DEV_RADIO2, 8'h01, 1'b0, '1, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_READ, DEV_RADIO1, 8'hFF, 1'b0, 8'hFF, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_READ, DEV_RADIO2, 8'h5A, 1'b1, 8'h00, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_SELECT, DEV_RADIO1, 8'h00, 1'b1, '0, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_WRITE, DEV_FPGA, 8'h5A, 1'b0, '0, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_READ, DEV_FPGA, 8'h00, 1'b0, 8'h3C, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_SELECT, DEV_RADIO2, 8'h00, 1'b1, '0, 1'b0, '0));
		dir_ops.push_back(mk_row(1'b1, MODE_WRITE, DEV_FLASH, 8'hC3, 1'b0, '0, 1'b0, '0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_ops.size(); i++)
			run_op(dir_ops[i].lead, dir_ops[i].din_word, dir_ops[i].typed, dir_ops[i].want);

		// mostly well-formed word operations, some select-only and idle ticks
		while (items_sent < ITEMS_TOTAL) begin
			quiet = (items_sent > ITEMS_TOTAL - QUIET_TAIL);
			pick  = $urandom_range(0, 9);
			b     = rand_beat();
			b.start = 1'b1;
			if (pick < 7)
				b.mode = ($urandom_range(0, 1) != 0) ? MODE_READ : MODE_WRITE;
			else if (pick < 9)
				b.mode = ($urandom_range(0, 1) != 0) ? MODE_SELECT_ALT : MODE_SELECT;
			else
				b.start = 1'b0;
			run_op(b, word_t'($urandom), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_pins.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
